// ===== rtl/dtsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsr_pkg
// Shared types and constants for the decimal truncated square root core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsr_pkg;

    localparam int INT_BITS   = 24;
    localparam int FRAC_BITS  = 32;
    localparam int MAX_DIGITS = 15;

    // fixed field widths of the request and result
    localparam int RADICAND_W = 56;
    localparam int DIGITS_W   = 4;
    localparam int ROOT_OUT_W = 62;

    localparam int RAD_BITS = INT_BITS + FRAC_BITS;
    // bits added by 100^MAX_DIGITS, i.e. 2*MAX_DIGITS*log2(10), rounded up
    localparam int GROWTH_BITS = (MAX_DIGITS * 2 * 3322 + 999) / 1000;
    localparam int SCALED_BITS = RAD_BITS + GROWTH_BITS;
    // integer square root runs over (scaled >> FRAC_BITS), two bits per step
    localparam int ROOT_BITS = (SCALED_BITS - FRAC_BITS + 1) / 2;
    localparam int T_W       = FRAC_BITS + 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 1;

    localparam int SCALE_STEPS = 2 * MAX_DIGITS;
    localparam int CNT_MAX     = (ROOT_BITS > SCALE_STEPS) ? ROOT_BITS : SCALE_STEPS;
    localparam int CNT_W       = $clog2(CNT_MAX + 1);

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        logic [DIGITS_W-1:0]   frac_digits;
    } in_req_t;

    typedef struct packed {
        logic [ROOT_OUT_W-1:0] root_scaled;
        logic [DIGITS_W-1:0]   digits_used;
    } out_req_t;

    typedef struct packed {
        logic load;
        logic mul10;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic [DIGITS_W-1:0] digits;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/decimal_truncated_square_root_core.sv =====
// ----------------------------------------------------------------------------
// decimal_truncated_square_root_core
// floor(sqrt(radicand) * 10^k) for a 24.32 fixed point radicand, k <= 15.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries a radicand and a digit
//   count k; k above 15 is clamped to 15 and echoed as digits_used.
//   Output channel out_valid/out_stall/out_data returns one result per request.
//   One request is in flight at a time: in_stall stays high from acceptance
//   until the result has been taken.
//   Sequence: a load, x10 scaling on a shift-add unit (two passes per
//   digit), a turnaround, 62 root steps (two radicand bits per step on one
//   65-bit subtract/compare), then the result shows.
//   A stalled result is held unchanged in the datapath registers until
//   out_stall drops; no new request is taken meanwhile.
//   Reset returns the sequencer to idle with no result pending; no memory
//   to clear, so a request can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_truncated_square_root_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  dtsr_pkg::in_req_t   in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output dtsr_pkg::out_req_t  out_data
);

    dtsr_pkg::dp_cmd_t    cmd;
    dtsr_pkg::dp_status_t status;

    dtsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dtsr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/dtsr_datapath.sv =====
// ----------------------------------------------------------------------------
// dtsr_datapath
// Decimal scaling by repeated x10 and a two-bits-per-step integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsr_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dtsr_pkg::in_req_t    in_data,
    input  dtsr_pkg::dp_cmd_t    cmd,
    output dtsr_pkg::dp_status_t status,
    output dtsr_pkg::out_req_t   out_data
);

    logic [dtsr_pkg::T_W-1:0]       t_reg, t_next;
    logic [dtsr_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [dtsr_pkg::ROOT_BITS-1:0] root_reg, root_next;
    logic [dtsr_pkg::DIGITS_W-1:0]  k_reg, k_next;

    logic [dtsr_pkg::ROOT_BITS+2:0] shifted;
    logic [dtsr_pkg::ROOT_BITS+2:0] trial;
    logic [dtsr_pkg::ROOT_BITS+2:0] diff;
    logic                           ge;
    logic [dtsr_pkg::DIGITS_W-1:0]  k_sat;

    always_comb
    begin
        k_sat = (in_data.frac_digits > dtsr_pkg::DIGITS_W'(dtsr_pkg::MAX_DIGITS))
              ? dtsr_pkg::DIGITS_W'(dtsr_pkg::MAX_DIGITS) : in_data.frac_digits;

        // bring down the next pair of radicand bits
        shifted = {rem_reg, t_reg[dtsr_pkg::T_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);

        t_next    = t_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        k_next    = k_reg;

        if (cmd.load)
        begin
            t_next    = dtsr_pkg::T_W'(in_data.radicand[dtsr_pkg::RAD_BITS-1:0]);
            rem_next  = '0;
            root_next = '0;
            k_next    = k_sat;
        end
        else if (cmd.mul10)
        begin
            t_next = (t_reg << 3) + (t_reg << 1);
        end
        else if (cmd.step)
        begin
            t_next    = t_reg << 2;
            rem_next  = ge ? diff[dtsr_pkg::REM_W-1:0] : shifted[dtsr_pkg::REM_W-1:0];
            root_next = {root_reg[dtsr_pkg::ROOT_BITS-2:0], ge};
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        k_reg    <= k_next;
    end

    assign status.digits        = k_reg;
    assign out_data.root_scaled = dtsr_pkg::ROOT_OUT_W'(root_reg);
    assign out_data.digits_used = k_reg;

`ifndef SYNTHESIS
    // saturation must keep the digit count in range
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load) |-> (k_reg <= dtsr_pkg::DIGITS_W'(dtsr_pkg::MAX_DIGITS)))
        else $error("digit count above maximum after load");
`endif

endmodule

`default_nettype wire

// ===== rtl/dtsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtsr_ctrl
// Sequencer: load, decimal scaling passes, root steps, result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsr_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire                   out_stall,
    input  dtsr_pkg::dp_status_t  status,
    output dtsr_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        IDLE,
        SCALE,
        ROOT,
        DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [dtsr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dtsr_pkg::CNT_W-1:0] scale_target;

    assign scale_target = dtsr_pkg::CNT_W'({status.digits, 1'b0});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = SCALE;
                end
            end
            SCALE:
            begin
                // two x10 passes per decimal digit
                if (cnt_reg == scale_target)
                begin
                    cnt_next   = '0;
                    state_next = ROOT;
                end
                else
                begin
                    cmd.mul10 = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ROOT:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dtsr_pkg::CNT_W'(dtsr_pkg::ROOT_BITS - 1))
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (!out_stall)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = (state_reg == DONE);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul10, cmd.step}))
        else $error("more than one datapath command");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("new request taken while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == SCALE) && (cnt_reg == '0))
        else $error("load not followed by scaling");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ROOT) |-> (cnt_reg < dtsr_pkg::CNT_W'(dtsr_pkg::ROOT_BITS)))
        else $error("root step count overrun");
`endif

endmodule

`default_nettype wire
